/* hdl/cube_face_to_sphere_direction_top_defines.svh */
// Assertion helpers used by the top-level design file.
`ifndef CUBE_FACE_TO_SPHERE_DIRECTION_TOP_DEFINES_SVH
`define CUBE_FACE_TO_SPHERE_DIRECTION_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CFSD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define CFSD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/cfsd_pkg.sv */
// ----------------------------------------------------------------------------
// cfsd_pkg
// Types and constants for the cube face to sphere direction block.
// ----------------------------------------------------------------------------
package cfsd_pkg;

	localparam int RW = 11;     // resolution and grid width
	localparam int VW = RW + 1; // signed vector component width
	localparam int SW = 24;     // squared length width
	localparam int QW = 15;     // quotient bits, 0..16384
	localparam int PW = 58;     // running product width, signed
	localparam int FRAC_BITS = 14;

	localparam logic [2:0] FACE_PX = 3'd0;
	localparam logic [2:0] FACE_NX = 3'd1;
	localparam logic [2:0] FACE_PY = 3'd2;
	localparam logic [2:0] FACE_NY = 3'd3;
	localparam logic [2:0] FACE_PZ = 3'd4;

	typedef struct packed {
		logic [2:0]    face;
		logic [RW-1:0] grid_x;
		logic [RW-1:0] grid_y;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
	} out_item_t;

endpackage

/* hdl/cfsd_lane.sv */
// ----------------------------------------------------------------------------
// cfsd_lane
// One component: pipelined bit search for round(16384*m/sqrt(s)).
// ----------------------------------------------------------------------------
module cfsd_lane (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         vld_in,
	input  logic [cfsd_pkg::RW-1:0]      mag,
	input  logic                         neg,
	input  logic [cfsd_pkg::SW-1:0]      sum,
	output logic                         vld_out,
	output logic signed [15:0]           dir
);
	localparam int QW = cfsd_pkg::QW;
	localparam int PW = cfsd_pkg::PW;

	logic                 vld_s [0:QW];
	logic                 neg_s [0:QW];
	logic [PW-1:0]        rhs_s [0:QW];
	logic signed [PW-1:0] p_s   [0:QW];
	logic signed [PW-1:0] es_s  [0:QW];
	logic [PW-1:0]        sum_s [0:QW];
	logic [QW-1:0]        q_s   [0:QW];

	logic [2*cfsd_pkg::RW-1:0] mag_sq;
	assign mag_sq = mag * mag;

	// stage 0: rhs = 2^30 * m^2, e = -1 so e^2*s = s and e*s = -s
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		rhs_s[0] <= PW'(mag_sq) << (2 * cfsd_pkg::FRAC_BITS + 2);
		sum_s[0] <= PW'(sum);
		p_s[0]   <= $signed(PW'(sum));
		es_s[0]  <= -$signed(PW'(sum));
		q_s[0]   <= '0;
		neg_s[0] <= neg;
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic signed [PW-1:0] p_try;
		logic                 take;

		// try setting bit QW-1-k: (e + 2bit)^2 s = e^2 s + 4bit*e s + 4bit^2 s
		assign p_try = p_s[k] + (es_s[k] <<< (QW + 1 - k))
		               + $signed(sum_s[k] << (2 * (QW - 1 - k) + 2));
		assign take  = !q_s[k][QW-1] && (p_try <= $signed(rhs_s[k]));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rhs_s[k+1] <= rhs_s[k];
			sum_s[k+1] <= sum_s[k];
			neg_s[k+1] <= neg_s[k];
			if (take) begin
				p_s[k+1]  <= p_try;
				es_s[k+1] <= es_s[k] + $signed(sum_s[k] << (QW - k));
				q_s[k+1]  <= q_s[k] | (QW'(1) << (QW - 1 - k));
			end else begin
				p_s[k+1]  <= p_s[k];
				es_s[k+1] <= es_s[k];
				q_s[k+1]  <= q_s[k];
			end
		end
	end

	assign vld_out = vld_s[QW];
	assign dir = neg_s[QW] ? -$signed({1'b0, q_s[QW]}) : $signed({1'b0, q_s[QW]});

endmodule

/* hdl/cube_face_to_sphere_direction_top.sv */
// ----------------------------------------------------------------------------
// cube_face_to_sphere_direction_top
// Cube face vertex to unit sphere direction in signed Q2.14.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_item (face, grid_x, grid_y) and raise start; the item is taken
//   at any edge with start high, busy is always low.
//   Each item yields one result on result, marked by done for one cycle.
//   A new item can enter every cycle. The pipeline holds three stages of
//   clamp, vector build and squared length, one lane setup stage, the
//   15-step quotient search with one stage per bit, and one output
//   register. The resolution register is written with res_we/res_wdata;
//   the user must write it only while no item is in flight, the block does
//   not enforce this. Zero reads as one, values above MAX_RES saturate.
//   Reset clears all valid bits and sets the resolution to 64.
//   The receiver cannot stall; done and result are never held back.
// ----------------------------------------------------------------------------
`include "cube_face_to_sphere_direction_top_defines.svh"

module cube_face_to_sphere_direction_top #(
	parameter int MAX_RES = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  cfsd_pkg::in_item_t         in_item,
	input  logic                       res_we,
	input  logic [cfsd_pkg::RW-1:0]    res_wdata,
	output logic                       done,
	output cfsd_pkg::out_item_t        result
);
	localparam int RW  = cfsd_pkg::RW;
	localparam int VW  = cfsd_pkg::VW;
	localparam int SW  = cfsd_pkg::SW;
	localparam int LAT = cfsd_pkg::QW + 5;

	logic [RW-1:0] resolution_q;
	logic          accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resolution_q <= RW'(64);
		end else if (res_we) begin
			resolution_q <= res_wdata;
		end
	end

	// stage 1: clamp and center
	logic [RW-1:0] r_c, gx_c, gy_c;
	always_comb begin
		priority if (resolution_q == '0) begin
			r_c = RW'(1);
		end else if (32'(resolution_q) > MAX_RES) begin
			r_c = RW'(MAX_RES);
		end else begin
			r_c = resolution_q;
		end
		gx_c = (in_item.grid_x > r_c) ? r_c : in_item.grid_x;
		gy_c = (in_item.grid_y > r_c) ? r_c : in_item.grid_y;
	end

	logic                 vld_s1;
	logic [2:0]           face_s1;
	logic signed [VW-1:0] r_s1, a_s1, b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		face_s1 <= in_item.face;
		r_s1    <= $signed({1'b0, r_c});
		a_s1    <= VW'($signed({1'b0, gx_c, 1'b0}) - $signed({2'b0, r_c}));
		b_s1    <= VW'($signed({1'b0, gy_c, 1'b0}) - $signed({2'b0, r_c}));
	end

	// stage 2: face select and squares
	logic signed [VW-1:0] vx_c, vy_c, vz_c;
	always_comb begin
		unique case (face_s1)
			cfsd_pkg::FACE_PX: begin vx_c = r_s1;  vy_c = -b_s1; vz_c = -a_s1; end
			cfsd_pkg::FACE_NX: begin vx_c = -r_s1; vy_c = -b_s1; vz_c = a_s1;  end
			cfsd_pkg::FACE_PY: begin vx_c = a_s1;  vy_c = r_s1;  vz_c = b_s1;  end
			cfsd_pkg::FACE_NY: begin vx_c = a_s1;  vy_c = -r_s1; vz_c = -b_s1; end
			cfsd_pkg::FACE_PZ: begin vx_c = a_s1;  vy_c = -b_s1; vz_c = r_s1;  end
			default:           begin vx_c = -a_s1; vy_c = -b_s1; vz_c = -r_s1; end
		endcase
	end

	logic                 vld_s2;
	logic signed [VW-1:0] vx_s2, vy_s2, vz_s2;
	logic [SW-1:0]        rr_s2, aa_s2, bb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	// widen before squaring so the product keeps all its bits
	always_ff @(posedge clk) begin
		vx_s2 <= vx_c;
		vy_s2 <= vy_c;
		vz_s2 <= vz_c;
		rr_s2 <= $unsigned(SW'(r_s1) * SW'(r_s1));
		aa_s2 <= $unsigned(SW'(a_s1) * SW'(a_s1));
		bb_s2 <= $unsigned(SW'(b_s1) * SW'(b_s1));
	end

	// stage 3: squared length, magnitudes and signs
	logic                 vld_s3;
	logic [SW-1:0]        sum_s3;
	logic [RW-1:0]        mx_s3, my_s3, mz_s3;
	logic                 nx_s3, ny_s3, nz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		sum_s3 <= rr_s2 + aa_s2 + bb_s2;
		nx_s3  <= vx_s2[VW-1];
		ny_s3  <= vy_s2[VW-1];
		nz_s3  <= vz_s2[VW-1];
		mx_s3  <= RW'(vx_s2[VW-1] ? -vx_s2 : vx_s2);
		my_s3  <= RW'(vy_s2[VW-1] ? -vy_s2 : vy_s2);
		mz_s3  <= RW'(vz_s2[VW-1] ? -vz_s2 : vz_s2);
	end

	logic               lx_vld, ly_vld, lz_vld;
	logic signed [15:0] lx_dir, ly_dir, lz_dir;

	cfsd_lane u_lane_x (
		.clk(clk), .arst_n(arst_n), .vld_in(vld_s3), .mag(mx_s3), .neg(nx_s3),
		.sum(sum_s3), .vld_out(lx_vld), .dir(lx_dir)
	);
	cfsd_lane u_lane_y (
		.clk(clk), .arst_n(arst_n), .vld_in(vld_s3), .mag(my_s3), .neg(ny_s3),
		.sum(sum_s3), .vld_out(ly_vld), .dir(ly_dir)
	);
	cfsd_lane u_lane_z (
		.clk(clk), .arst_n(arst_n), .vld_in(vld_s3), .mag(mz_s3), .neg(nz_s3),
		.sum(sum_s3), .vld_out(lz_vld), .dir(lz_dir)
	);

	logic done_q;
	cfsd_pkg::out_item_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= lx_vld;
		end
	end

	always_ff @(posedge clk) begin
		result_q.dir_x <= lx_dir;
		result_q.dir_y <= ly_dir;
		result_q.dir_z <= lz_dir;
	end

	assign done   = done_q;
	assign result = result_q;

	`CFSD_ASSERT_IMP(a_lanes_aligned, lx_vld, ly_vld && lz_vld, "lanes out of step")
	`CFSD_ASSERT_IMP(a_len_nonzero, vld_s3, sum_s3 != '0, "zero vector length")
	`CFSD_ASSERT_IMP(a_done_latency, done, $past(accept, LAT), "result without item")
	`CFSD_ASSERT_NXT(a_dir_range, lx_vld,
		(result.dir_x <= 16384) && (result.dir_x >= -16384) &&
		(result.dir_z <= 16384) && (result.dir_z >= -16384), "direction out of range")

endmodule
